// File: design/ple_pkg.sv
`default_nettype none
package ple_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = 7;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 3;

    // priority encode in groups of GRP_N cells
    localparam int GRP_N   = 8;
    localparam int GRP_W   = $clog2(GRP_N);
    localparam int GRP_CNT = (CAPACITY + GRP_N - 1) / GRP_N;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOCATE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic                     go;
        logic                     shift_up;
        logic                     shift_down;
        logic                     match_en;
        logic [IDX_W-1:0]         slot;
        logic [LEN_W-1:0]         length;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

endpackage
`default_nettype wire

// File: design/ple_cell.sv
`default_nettype none
module ple_cell (
    input  wire                              i_clk,
    input  wire ple_pkg::t_cmd               i_cmd,
    input  wire [ple_pkg::IDX_W-1:0]         i_index,
    input  wire signed [ple_pkg::DATA_W-1:0] i_left,
    input  wire signed [ple_pkg::DATA_W-1:0] i_right,
    output logic signed [ple_pkg::DATA_W-1:0] o_data,
    output logic                             o_match
);
    import ple_pkg::*;

    logic signed [DATA_W-1:0] r_data, n_data;
    logic                     r_match, n_match;

    always_comb begin
        n_data  = r_data;
        n_match = r_match;
        if (i_cmd.go) begin
            if (i_cmd.shift_up) begin
                if (i_index > i_cmd.slot) begin
                    n_data = i_left;
                end else if (i_index == i_cmd.slot) begin
                    n_data = i_cmd.value;
                end
            end
            if (i_cmd.shift_down && (i_index >= i_cmd.slot)) begin
                n_data = i_right;
            end
            // only live entries may match
            n_match = i_cmd.match_en && ({1'b0, i_index} < LEN_W'(i_cmd.length))
                      && (r_data == i_cmd.value);
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule
`default_nettype wire

// File: design/ple_find.sv
`default_nettype none
module ple_find (
    input  wire                      i_clk,
    input  wire [ple_pkg::CAPACITY-1:0] i_match,
    output logic                     o_any,
    output logic [ple_pkg::IDX_W-1:0] o_idx
);
    import ple_pkg::*;

    localparam int PAD_W = GRP_CNT * GRP_N;

    logic [PAD_W-1:0]  w_pad;
    logic [GRP_CNT-1:0] r_grp_any, n_grp_any;
    logic [GRP_W-1:0]  r_grp_idx [GRP_CNT];
    logic [GRP_W-1:0]  n_grp_idx [GRP_CNT];
    logic              r_any, n_any;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  w_full_idx;

    assign w_pad = PAD_W'(i_match);

    // first level: lowest set bit within each group
    always_comb begin
        for (int g = 0; g < GRP_CNT; g++) begin
            n_grp_any[g] = 1'b0;
            n_grp_idx[g] = '0;
            for (int b = GRP_N - 1; b >= 0; b--) begin
                if (w_pad[g*GRP_N + b]) begin
                    n_grp_any[g] = 1'b1;
                    n_grp_idx[g] = GRP_W'(b);
                end
            end
        end
    end

    // second level: lowest group with a hit
    always_comb begin
        n_any      = 1'b0;
        w_full_idx = '0;
        for (int g = GRP_CNT - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                n_any      = 1'b1;
                w_full_idx = IDX_W'(g * GRP_N) + IDX_W'(r_grp_idx[g]);
            end
        end
        n_idx = w_full_idx;
    end

    always_ff @(posedge i_clk) begin
        r_grp_any <= n_grp_any;
        for (int g = 0; g < GRP_CNT; g++) begin
            r_grp_idx[g] <= n_grp_idx[g];
        end
        r_any <= n_any;
        r_idx <= n_idx;
    end

    assign o_any = r_any;
    assign o_idx = r_idx;

endmodule
`default_nettype wire

// File: design/positional_list_engine.sv
`default_nettype none
// The result strobe o_valid follows the accept edge through the registered cell compare,
// the two-level registered priority encoder and the output register; busy is high from
// accept until the output register loads, so no new request is taken while one is still
// in flight.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active low) empties the list; stored words are undefined until written.
module positional_list_engine (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire [ple_pkg::KIND_W-1:0]         i_kind,
    input  wire [ple_pkg::POS_W-1:0]          i_position,
    input  wire signed [ple_pkg::DATA_W-1:0]  i_value,
    output logic                              o_valid,
    output logic [ple_pkg::STAT_W-1:0]        o_status,
    output logic [ple_pkg::POS_W-1:0]         o_found_at,
    output logic [ple_pkg::LEN_W-1:0]         o_count_now
);
    import ple_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_MATCH = 2'd1;
    localparam logic [1:0] PH_GROUP = 2'd2;
    localparam logic [1:0] PH_SEL   = 2'd3;

    logic [1:0]        r_phase, n_phase;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [KIND_W-1:0] r_kind;
    logic [STAT_W-1:0] r_stat, n_stat;
    logic [LEN_W-1:0]  r_len_before;
    logic              r_valid;
    logic [STAT_W-1:0] r_out_stat, n_out_stat;
    logic [POS_W-1:0]  r_out_found, n_out_found;
    logic [LEN_W-1:0]  r_out_len;

    logic              w_accept;
    t_cmd              w_cmd;
    logic [LEN_W:0]    w_len_p1;
    logic [IDX_W-1:0]  w_pos_m1;

    logic signed [DATA_W-1:0] w_data [CAPACITY];
    logic [CAPACITY-1:0]      w_match;
    logic                     w_any;
    logic [IDX_W-1:0]         w_idx;

    assign w_accept = start && !busy;
    assign w_len_p1 = {1'b0, r_len} + (LEN_W+1)'(1);
    assign w_pos_m1 = IDX_W'(i_position - POS_W'(1));

    // decode and range check
    always_comb begin
        n_stat           = ST_OK;
        n_len            = r_len;
        w_cmd.go         = w_accept;
        w_cmd.shift_up   = 1'b0;
        w_cmd.shift_down = 1'b0;
        w_cmd.match_en   = 1'b0;
        w_cmd.slot       = w_pos_m1;
        w_cmd.length     = r_len;
        w_cmd.value      = i_value;
        unique case (i_kind)
            KIND_INSERT: begin
                if ((i_position == '0) || ({1'b0, i_position} > w_len_p1)) begin
                    n_stat = ST_BAD_POS;
                end else if (r_len == LEN_W'(CAPACITY)) begin
                    n_stat = ST_FULL;
                end else begin
                    w_cmd.shift_up = 1'b1;
                    n_len          = w_len_p1[LEN_W-1:0];
                end
            end
            KIND_DELETE: begin
                if ((i_position == '0) || (i_position > POS_W'(r_len))) begin
                    n_stat = ST_BAD_POS;
                end else begin
                    w_cmd.shift_down = 1'b1;
                    n_len            = r_len - LEN_W'(1);
                end
            end
            KIND_LOCATE: begin
                w_cmd.match_en = 1'b1;
            end
            KIND_UNUSED: begin
                n_stat = ST_BAD_POS;
            end
            default: begin
                n_stat = ST_BAD_POS;
            end
        endcase
        if (!w_accept) begin
            n_len = r_len;
        end
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [DATA_W-1:0] w_left, w_right;
        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[k+1];
        end
        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (IDX_W'(k)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[k]),
            .o_match (w_match[k])
        );
    end

    ple_find u_find (
        .i_clk   (i_clk),
        .i_match (w_match),
        .o_any   (w_any),
        .o_idx   (w_idx)
    );

    always_comb begin
        unique case (r_phase)
            PH_IDLE:  n_phase = w_accept ? PH_MATCH : PH_IDLE;
            PH_MATCH: n_phase = PH_GROUP;
            PH_GROUP: n_phase = PH_SEL;
            PH_SEL:   n_phase = PH_IDLE;
            default:  n_phase = PH_IDLE;
        endcase
    end

    always_comb begin
        n_out_stat  = r_stat;
        n_out_found = '0;
        if (r_kind == KIND_LOCATE) begin
            if (r_len_before == '0) begin
                n_out_stat = ST_EMPTY;
            end else if (w_any) begin
                n_out_stat  = ST_OK;
                n_out_found = POS_W'(w_idx) + POS_W'(1);
            end else begin
                n_out_stat = ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_valid <= (r_phase == PH_SEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind       <= i_kind;
            r_stat       <= n_stat;
            r_len_before <= r_len;
        end
        if (r_phase == PH_SEL) begin
            r_out_stat  <= n_out_stat;
            r_out_found <= n_out_found;
            r_out_len   <= r_len;
        end
    end

    assign busy        = (r_phase != PH_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_out_stat;
    assign o_found_at  = r_out_found;
    assign o_count_now = r_out_len;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy not raised after accept");

    a_strobe_after_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> ##3 o_valid)
        else $error("result strobe missing");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_found_at != '0)) |-> (o_status == ST_OK))
        else $error("found position with non-ok status");

endmodule
`default_nettype wire
